// ===== rtl/dtlv_pkg.sv =====
// Package for the DER-coded TLV stream parser.
// Holds the word types, byte role and status codes and shared constants; no dependencies.
`timescale 1ns / 1ps

package dtlv_pkg;

  // Default for the widest long-form field, in bytes after the prefix.
  localparam int unsigned MaxLongBytesDefault = 4;

  localparam logic [7:0]  LongFlag   = 8'h80;
  localparam logic [7:0]  TagMax     = 8'hff;
  localparam logic [15:0] LenMax     = 16'hffff;
  localparam logic [31:0] AccSatMark = 32'h00ff_ffff;

  typedef enum logic [1:0] {
    PhTag = 2'd0,
    PhLen = 2'd1,
    PhVal = 2'd2,
    PhRsv = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindTag     = 2'd0,
    KindLength  = 2'd1,
    KindValue   = 2'd2,
    KindDiscard = 2'd3
  } byte_kind_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTruncated = 3'd1,
    StBadCount  = 3'd2,
    StTagLarge  = 3'd3,
    StLenLarge  = 3'd4,
    StTooLong   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [15:0] value_offset;
    logic [7:0]  current_tag;
    logic [15:0] current_length;
    logic        element_done;
    logic [15:0] elem_size;
    logic [2:0]  status;
    logic        payload_end;
  } out_word_t;

endpackage

// ===== rtl/dtlv_step.sv =====
// Parser state registers and the per-byte next-state and result logic.
// Depends on dtlv_pkg for word types and codes.
`timescale 1ns / 1ps

module dtlv_step import dtlv_pkg::*; #(
  parameter int unsigned MAX_LONG_BYTES = MaxLongBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  in_word_t  word_i,
  output out_word_t word_o
);

  localparam int unsigned LeftW = $clog2(MAX_LONG_BYTES + 1);

  logic [1:0]       phase_q, phase_d;
  logic             long_q, long_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [31:0]      acc_q, acc_d;
  logic [7:0]       tag_q, tag_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      vseen_q, vseen_d;
  logic [15:0]      ecount_q, ecount_d;
  logic [16:0]      pcount_q, pcount_d;
  logic [2:0]       err_q, err_d;

  always_comb begin
    logic [1:0]       kind;
    logic [15:0]      off;
    logic [15:0]      raw;
    logic [7:0]       tag_out;
    logic [15:0]      len_out;
    logic             done;
    logic             fin_en;
    logic [31:0]      fin_v;
    logic [6:0]       cnt;
    logic [7:0]       b;
    logic             last;

    b        = word_i.data_byte;
    last     = word_i.last_byte;
    phase_d  = phase_q;
    long_d   = long_q;
    left_d   = left_q;
    acc_d    = acc_q;
    tag_d    = tag_q;
    len_d    = len_q;
    vseen_d  = vseen_q;
    ecount_d = ecount_q;
    pcount_d = pcount_q;
    err_d    = err_q;
    kind     = KindDiscard;
    off      = '0;
    raw      = '0;
    tag_out  = '0;
    len_out  = '0;
    done     = 1'b0;
    fin_en   = 1'b0;
    fin_v    = '0;
    cnt      = b[6:0];

    if (err_q == StOk) begin
      if (!pcount_q[16]) begin
        pcount_d = pcount_q + 17'd1;
      end
      if (pcount_d[16]) begin
        err_d = StTooLong;
      end else begin
        if (ecount_q != 16'hffff) begin
          ecount_d = ecount_q + 16'd1;
        end
        if (phase_q == PhVal) begin
          kind    = KindValue;
          off     = vseen_q;
          vseen_d = vseen_q + 16'd1;
          if (vseen_d >= len_q) begin
            done    = 1'b1;
            phase_d = PhTag;
          end
        end else begin
          // The reserved phase code behaves as the tag phase.
          phase_d = (phase_q == PhLen) ? PhLen : PhTag;
          kind    = (phase_d == PhLen) ? KindLength : KindTag;
          if (long_q) begin
            acc_d = (acc_q > AccSatMark) ? 32'hffff_ffff : {acc_q[23:0], b};
            if (left_q != '0) begin
              left_d = left_q - LeftW'(1);
            end
            if (left_d == '0) begin
              long_d = 1'b0;
              fin_en = 1'b1;
              fin_v  = acc_d;
            end
          end else if ((b & LongFlag) != 8'd0) begin
            if (last) begin
              err_d = StTruncated;
            end else if (cnt == 7'd0 || cnt > 7'(MAX_LONG_BYTES)) begin
              err_d = StBadCount;
            end else begin
              long_d = 1'b1;
              left_d = cnt[LeftW-1:0];
              acc_d  = '0;
            end
          end else begin
            fin_en = 1'b1;
            fin_v  = {24'd0, b};
          end

          // A tag or length field has been fully decoded.
          if (fin_en) begin
            if (phase_d == PhLen) begin
              if (fin_v > {16'd0, LenMax}) begin
                err_d = StLenLarge;
              end else begin
                len_d   = fin_v[15:0];
                vseen_d = '0;
                if (fin_v == 32'd0) begin
                  phase_d = PhTag;
                  done    = 1'b1;
                end else begin
                  phase_d = PhVal;
                end
              end
            end else begin
              if (fin_v > {24'd0, TagMax}) begin
                err_d = StTagLarge;
              end else begin
                tag_d   = fin_v[7:0];
                phase_d = PhLen;
              end
            end
          end
        end
        if (done) begin
          raw      = ecount_d;
          ecount_d = '0;
        end
      end

      if (err_d != StOk) begin
        phase_d = PhTag;
        long_d  = 1'b0;
        left_d  = '0;
        done    = 1'b0;
        raw     = '0;
      end else begin
        if (phase_d != PhTag || done) tag_out = tag_d;
        if (phase_d == PhVal || done) len_out = len_d;
      end
    end

    // Ending off an element boundary is a truncation.
    if (last && err_d == StOk && (phase_d != PhTag || long_d)) begin
      err_d = StTruncated;
    end

    word_o.byte_kind      = kind;
    word_o.value_offset   = off;
    word_o.current_tag    = tag_out;
    word_o.current_length = len_out;
    word_o.element_done   = done;
    word_o.elem_size      = raw;
    word_o.status         = err_d;
    word_o.payload_end    = last;

    // The parser starts afresh after the final byte of a payload.
    if (last) begin
      phase_d  = PhTag;
      long_d   = 1'b0;
      left_d   = '0;
      acc_d    = '0;
      tag_d    = '0;
      len_d    = '0;
      vseen_d  = '0;
      ecount_d = '0;
      pcount_d = '0;
      err_d    = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTag;
      long_q   <= 1'b0;
      left_q   <= '0;
      acc_q    <= '0;
      tag_q    <= '0;
      len_q    <= '0;
      vseen_q  <= '0;
      ecount_q <= '0;
      pcount_q <= '0;
      err_q    <= StOk;
    end else if (go_i) begin
      phase_q  <= phase_d;
      long_q   <= long_d;
      left_q   <= left_d;
      acc_q    <= acc_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      vseen_q  <= vseen_d;
      ecount_q <= ecount_d;
      pcount_q <= pcount_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== rtl/der_tlv_stream_parser_top.sv =====
// Top level of the DER-coded TLV stream parser: input register, parser step, result register.
// Depends on dtlv_pkg and dtlv_step.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_stall_o    in_word_t  (data_byte, last_byte)
// out       output     out_valid_o / out_stall_i  out_word_t (role, tag, length, status ...)
//
// One byte is taken per cycle when the output is not stalled; each byte's result word is
// presented from the result register. The rate is set by the single parser state update,
// which runs once per byte between the input register and the result register.
// Reset clears the parser to the tag phase with no error and empties both registers.
// A stalled result holds in the result register while one more byte waits in the input
// register; only then is the input stalled.

module der_tlv_stream_parser_top import dtlv_pkg::*; #(
  parameter int unsigned MAX_LONG_BYTES = MaxLongBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic      in_full_q, in_full_d;
  in_word_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q;
  out_word_t step_word;
  logic      step_go;
  logic      in_take;

  // The held byte is processed whenever the result register is free or being emptied.
  assign step_go    = in_full_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_full_q && !step_go;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_full_d   = in_take || (in_full_q && !step_go);
  assign out_valid_d = step_go || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only on a transfer and need no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step_go) begin
      out_q <= step_word;
    end
  end

  dtlv_step #(
    .MAX_LONG_BYTES(MAX_LONG_BYTES)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (step_go),
    .word_i (in_q),
    .word_o (step_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
